### hdl/ps2mpt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// Used by the assembler, the cursor unit and the top level; no dependencies.
package ps2mpt_pkg;

    localparam logic [7:0] STAT_FULL   = 8'h01;
    localparam logic [7:0] STAT_AUX    = 8'h20;
    localparam logic [7:0] HDR_SYNC    = 8'h08;
    localparam logic [7:0] HDR_OVF     = 8'hC0;
    localparam logic [7:0] HDR_BUTTONS = 8'h07;
    localparam logic [15:0] POS_MAX    = 16'hFFFF;

    // Position of the next expected byte within a three-byte packet.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XMOVE  = 2'd1,
        PH_YMOVE  = 2'd2
    } t_phase;

    // A packet that completed without overflow, as seen by the cursor unit.
    typedef struct packed {
        logic       done;
        logic [7:0] header;
        logic [7:0] xmove;
        logic [7:0] ymove;
    } t_pkt;

    typedef struct packed {
        logic [15:0]       pos_x;
        logic [15:0]       pos_y;
        logic signed [7:0] delta_x;
        logic signed [8:0] delta_y;
        logic [2:0]        button_bits;
    } t_result;

endpackage

### hdl/ps2_mouse_packet_tracker_core.sv
// Top level of the PS/2 mouse packet tracker: input register, packet assembler,
// cursor unit and output register. Depends on ps2mpt_pkg, ps2mpt_assembler, ps2mpt_cursor.
//
// Each input item is one controller read (status byte and data byte). Reads that do
// not show output-full and aux source are ignored. Three-byte packets are assembled,
// resyncing on header bit 3; packets with an overflow bit are dropped. Each good
// packet yields one result item with the clamped position, the deltas (dy negated)
// and the button bits. An item is accepted every cycle while the output is not stalled:
// it is held in the input register, is processed there in a single pass, and its
// result lands in the output register, where it is presented once the last packet
// byte has passed through the input register. The output register holds a result
// while the sink stalls; the input register keeps accepting as long as its item can
// move on in the same cycle.
module ps2_mouse_packet_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] ctrl_status, [15:8] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // [15:0] pos_x, [31:16] pos_y, [39:32] delta_x,
                                     // [48:40] delta_y, [51:49] button_bits, [55:52] zero
);

    logic                r_in_valid;
    logic [7:0]          r_status;
    logic [7:0]          r_byte;
    logic                r_out_valid;
    ps2mpt_pkg::t_result r_out;
    logic                w_advance;
    ps2mpt_pkg::t_pkt    w_pkt;
    ps2mpt_pkg::t_result w_result;

    // The held read is processed when the output register is free or being drained.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    ps2mpt_assembler u_assembler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_status (r_status),
        .i_byte   (r_byte),
        .o_pkt    (w_pkt)
    );

    ps2mpt_cursor u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pkt    (w_pkt),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_status <= i_s_tdata[7:0];
            r_byte   <= i_s_tdata[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_pkt.done;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_pkt.done) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.button_bits, r_out.delta_y, r_out.delta_x,
                         r_out.pos_y, r_out.pos_x};

endmodule

### hdl/ps2mpt_assembler.sv
// Byte phase tracker that assembles three-byte PS/2 packets from controller reads.
// Depends on ps2mpt_pkg.
module ps2mpt_assembler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_status,
    input  logic [7:0]        i_byte,
    output ps2mpt_pkg::t_pkt  o_pkt
);

    ps2mpt_pkg::t_phase r_phase, n_phase;
    logic [7:0]         r_header, n_header;
    logic [7:0]         r_xmove, n_xmove;
    logic               w_live;

    // A read counts only when the buffer is full and the byte came from the aux port.
    assign w_live = i_step
                  && ((i_status & ps2mpt_pkg::STAT_FULL) != 8'h00)
                  && ((i_status & ps2mpt_pkg::STAT_AUX) != 8'h00);

    always_comb begin
        n_phase     = r_phase;
        n_header    = r_header;
        n_xmove     = r_xmove;
        o_pkt.done   = 1'b0;
        o_pkt.header = r_header;
        o_pkt.xmove  = r_xmove;
        o_pkt.ymove  = i_byte;
        if (w_live) begin
            case (r_phase)
                ps2mpt_pkg::PH_XMOVE: begin
                    n_xmove = i_byte;
                    n_phase = ps2mpt_pkg::PH_YMOVE;
                end
                ps2mpt_pkg::PH_YMOVE: begin
                    n_phase    = ps2mpt_pkg::PH_HEADER;
                    o_pkt.done = ((r_header & ps2mpt_pkg::HDR_OVF) == 8'h00);
                end
                default: begin
                    // Header slot: a byte without the sync bit is skipped.
                    if ((i_byte & ps2mpt_pkg::HDR_SYNC) != 8'h00) begin
                        n_header = i_byte;
                        n_phase  = ps2mpt_pkg::PH_XMOVE;
                    end else begin
                        n_phase  = ps2mpt_pkg::PH_HEADER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ps2mpt_pkg::PH_HEADER;
            r_header <= 8'h00;
            r_xmove  <= 8'h00;
        end else begin
            r_phase  <= n_phase;
            r_header <= n_header;
            r_xmove  <= n_xmove;
        end
    end

endmodule

### hdl/ps2mpt_cursor.sv
// Cursor position accumulator with clamping at zero and at the top of the 16-bit range.
// Depends on ps2mpt_pkg.
module ps2mpt_cursor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ps2mpt_pkg::t_pkt     i_pkt,
    output ps2mpt_pkg::t_result  o_result
);

    logic [15:0]        r_cursor_x, n_cursor_x;
    logic [15:0]        r_cursor_y, n_cursor_y;
    logic signed [7:0]  w_dx;
    logic signed [8:0]  w_neg_dy;
    logic signed [17:0] w_sum_x;
    logic signed [17:0] w_sum_y;

    assign w_dx     = $signed(i_pkt.xmove);
    assign w_neg_dy = -$signed({i_pkt.ymove[7], i_pkt.ymove});
    assign w_sum_x  = $signed({2'b00, r_cursor_x}) + 18'(w_dx);
    assign w_sum_y  = $signed({2'b00, r_cursor_y}) + 18'(w_neg_dy);

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        if (i_pkt.done) begin
            if (w_sum_x < 0) begin
                n_cursor_x = 16'h0000;
            end else if (w_sum_x > $signed({2'b00, ps2mpt_pkg::POS_MAX})) begin
                n_cursor_x = ps2mpt_pkg::POS_MAX;
            end else begin
                n_cursor_x = w_sum_x[15:0];
            end
            if (w_sum_y < 0) begin
                n_cursor_y = 16'h0000;
            end else if (w_sum_y > $signed({2'b00, ps2mpt_pkg::POS_MAX})) begin
                n_cursor_y = ps2mpt_pkg::POS_MAX;
            end else begin
                n_cursor_y = w_sum_y[15:0];
            end
        end
    end

    always_comb begin
        o_result.pos_x       = n_cursor_x;
        o_result.pos_y       = n_cursor_y;
        o_result.delta_x     = w_dx;
        o_result.delta_y     = w_neg_dy;
        o_result.button_bits = i_pkt.header[2:0] & ps2mpt_pkg::HDR_BUTTONS[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= 16'h0000;
            r_cursor_y <= 16'h0000;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
        end
    end

endmodule
